>>> hdl/calendar_date_stepper_core_assert.svh
// ----------------------------------------------------------------------------
// Calendar date stepper assertion macros
// Concurrent assertion macros on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_STEPPER_CORE_ASSERT_SVH
`define CALENDAR_DATE_STEPPER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CDS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("calendar date stepper: same-cycle check failed");

`define CDS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("calendar date stepper: next-cycle check failed");

`else

`define CDS_ASSERT_IMPL(label, ante, cons)

`define CDS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hdl/cds_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date stepper package
// Widths, month and function codes, controller state, command and status
// types, and the month length and leap year functions.
// ----------------------------------------------------------------------------
package cds_pkg;

	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int CNT_W  = 21;

	localparam logic [YEAR_W-1:0] YEAR_TOP     = 14'd16383;
	localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd9999;

	localparam logic FN_LOAD = 1'b0;
	localparam logic FN_STEP = 1'b1;

	localparam logic [MON_W-1:0] MON_JAN = 4'd1;
	localparam logic [MON_W-1:0] MON_FEB = 4'd2;
	localparam logic [MON_W-1:0] MON_APR = 4'd4;
	localparam logic [MON_W-1:0] MON_JUN = 4'd6;
	localparam logic [MON_W-1:0] MON_SEP = 4'd9;
	localparam logic [MON_W-1:0] MON_NOV = 4'd11;
	localparam logic [MON_W-1:0] MON_DEC = 4'd12;

	// inverse of 25 modulo 2^14, and the largest product of a multiple of 25
	localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
	localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_STEP,
		ST_FIN
	} cds_state_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic step;
		logic out_load;
	} cds_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic at_bound;
	} cds_sts_t;

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [YEAR_W-1:0] prod;
		logic              div25;
		prod  = YEAR_W'(y * INV25);
		div25 = (prod <= DIV25_LIM);
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m) inside
			MON_FEB: len = leap ? 5'd29 : 5'd28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

>>> hdl/calendar_date_stepper_core.sv
// ----------------------------------------------------------------------------
// Calendar date stepper core
// Gregorian date counter with load check and signed day stepping.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A load passes from acceptance to the
// result being offered through capture, check against month length and
// max_year, and hand-off. A step moves the date by |day_count| days, fewer
// when the date clamps at 1 January of year 1 or 31 December of year 16383;
// the datapath moves the date by exactly one day per cycle. The result
// sits in an output register; a new request is taken while it waits, and the
// next result is handed over once it has gone. max_year is written at any
// time through the configuration channel and a value of 0 acts as 1.
module calendar_date_stepper_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             func,
	input  logic [cds_pkg::DAY_W-1:0]        day,
	input  logic [cds_pkg::MON_W-1:0]        month,
	input  logic [cds_pkg::YEAR_W-1:0]       year,
	input  logic signed [cds_pkg::CNT_W-1:0] day_count,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [cds_pkg::DAY_W-1:0]        cur_day,
	output logic [cds_pkg::MON_W-1:0]        cur_month,
	output logic [cds_pkg::YEAR_W-1:0]       cur_year,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cds_pkg::YEAR_W-1:0]       cfg_data
);
	import cds_pkg::*;

	cds_cmd_t cmd;
	cds_sts_t sts;

	assign cfg_ready = 1'b1;

	cds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	cds_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.day       (day),
		.month     (month),
		.year      (year),
		.day_count (day_count),
		.sts       (sts),
		.cur_day   (cur_day),
		.cur_month (cur_month),
		.cur_year  (cur_year)
	);

`include "calendar_date_stepper_core_assert.svh"

	`CDS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
	`CDS_ASSERT_IMPL(a_month_range, out_valid, (cur_month >= MON_JAN) && (cur_month <= MON_DEC))
	`CDS_ASSERT_IMPL(a_date_nonzero, out_valid, (cur_day != '0) && (cur_year != '0))
	`CDS_ASSERT_IMPL(a_step_only_live, cmd.step, !sts.cnt_zero && !sts.at_bound)

endmodule

>>> hdl/cds_ctrl.sv
// ----------------------------------------------------------------------------
// Calendar date stepper controller
// Sequences capture, load check, day stepping and result hand-off.
// ----------------------------------------------------------------------------
module cds_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            func,
	input  logic            out_ready,
	input  cds_pkg::cds_sts_t sts,
	output logic            in_ready,
	output logic            out_valid,
	output cds_pkg::cds_cmd_t cmd
);
	import cds_pkg::*;

	cds_state_t state_q;
	cds_state_t state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (func == FN_STEP) ? ST_STEP : ST_LOAD;
				end
			end
			ST_LOAD: state_nxt = ST_FIN;
			ST_STEP: begin
				if (sts.cnt_zero || sts.at_bound) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_LOAD: cmd.load = 1'b1;
			ST_STEP: cmd.step = !(sts.cnt_zero || sts.at_bound);
			ST_FIN:  cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/cds_dpath.sv
// ----------------------------------------------------------------------------
// Calendar date stepper datapath
// Date registers, load check, one-day stepper, day counter and result register.
// ----------------------------------------------------------------------------
module cds_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cds_pkg::cds_cmd_t           cmd,
	input  logic                        cfg_we,
	input  logic [cds_pkg::YEAR_W-1:0]  cfg_data,
	input  logic [cds_pkg::DAY_W-1:0]   day,
	input  logic [cds_pkg::MON_W-1:0]   month,
	input  logic [cds_pkg::YEAR_W-1:0]  year,
	input  logic signed [cds_pkg::CNT_W-1:0] day_count,
	output cds_pkg::cds_sts_t           sts,
	output logic [cds_pkg::DAY_W-1:0]   cur_day,
	output logic [cds_pkg::MON_W-1:0]   cur_month,
	output logic [cds_pkg::YEAR_W-1:0]  cur_year
);
	import cds_pkg::*;

	logic [YEAR_W-1:0] max_year_q;
	logic [DAY_W-1:0]  day_q;
	logic [MON_W-1:0]  month_q;
	logic [YEAR_W-1:0] year_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              back_q;
	logic [DAY_W-1:0]  ld_day_q;
	logic [MON_W-1:0]  ld_month_q;
	logic [YEAR_W-1:0] ld_year_q;
	logic [DAY_W-1:0]  out_day_q;
	logic [MON_W-1:0]  out_month_q;
	logic [YEAR_W-1:0] out_year_q;

	logic [YEAR_W-1:0] top_year;
	logic [YEAR_W-1:0] leap_year;
	logic              leap;
	logic              ld_ok;
	logic [DAY_W-1:0]  len_cur;
	logic [DAY_W-1:0]  len_prev;
	logic [DAY_W-1:0]  day_nxt;
	logic [MON_W-1:0]  month_nxt;
	logic [YEAR_W-1:0] year_nxt;
	logic [CNT_W-1:0]  cnt_mag;

	assign top_year  = (max_year_q == '0) ? YEAR_W'(1) : max_year_q;
	assign leap_year = cmd.load ? ld_year_q : year_q;
	assign leap      = is_leap(leap_year);
	assign len_cur   = month_len(month_q, leap);
	assign len_prev  = month_len(month_q - MON_W'(1), leap);
	assign cnt_mag   = day_count[CNT_W-1] ? CNT_W'(-day_count) : CNT_W'(day_count);

	assign ld_ok = (ld_month_q >= MON_JAN) && (ld_month_q <= MON_DEC)
		&& (ld_year_q != '0) && (ld_year_q <= top_year)
		&& (ld_day_q != '0) && (ld_day_q <= month_len(ld_month_q, leap));

	always_comb begin
		day_nxt   = day_q;
		month_nxt = month_q;
		year_nxt  = year_q;
		if (!back_q) begin
			if (day_q == len_cur) begin
				day_nxt = DAY_W'(1);
				if (month_q == MON_DEC) begin
					month_nxt = MON_JAN;
					year_nxt  = year_q + YEAR_W'(1);
				end else begin
					month_nxt = month_q + MON_W'(1);
				end
			end else begin
				day_nxt = day_q + DAY_W'(1);
			end
		end else begin
			if (day_q == DAY_W'(1)) begin
				if (month_q == MON_JAN) begin
					day_nxt   = DAY_W'(31);
					month_nxt = MON_DEC;
					year_nxt  = year_q - YEAR_W'(1);
				end else begin
					day_nxt   = len_prev;
					month_nxt = month_q - MON_W'(1);
				end
			end else begin
				day_nxt = day_q - DAY_W'(1);
			end
		end
	end

	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.at_bound = back_q
		? ((year_q == YEAR_W'(1)) && (month_q == MON_JAN) && (day_q == DAY_W'(1)))
		: ((year_q == YEAR_TOP) && (month_q == MON_DEC) && (day_q == DAY_W'(31)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_year_q <= MAX_YEAR_RST;
			day_q      <= DAY_W'(1);
			month_q    <= MON_JAN;
			year_q     <= MAX_YEAR_RST;
			cnt_q      <= '0;
			back_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_year_q <= cfg_data;
			end
			if (cmd.capture) begin
				cnt_q  <= cnt_mag;
				back_q <= day_count[CNT_W-1];
			end else if (cmd.step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.load) begin
				if (ld_ok) begin
					day_q   <= ld_day_q;
					month_q <= ld_month_q;
					year_q  <= ld_year_q;
				end else begin
					day_q   <= DAY_W'(1);
					month_q <= MON_JAN;
					year_q  <= top_year;
				end
			end else if (cmd.step) begin
				day_q   <= day_nxt;
				month_q <= month_nxt;
				year_q  <= year_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ld_day_q   <= day;
			ld_month_q <= month;
			ld_year_q  <= year;
		end
		if (cmd.out_load) begin
			out_day_q   <= day_q;
			out_month_q <= month_q;
			out_year_q  <= year_q;
		end
	end

	assign cur_day   = out_day_q;
	assign cur_month = out_month_q;
	assign cur_year  = out_year_q;

endmodule
